// ===== rtl/core/crb_pkg.sv =====
// Shared types and constants of the client registry and frame broadcast unit.
package crb_pkg;

    localparam int FRAME_W       = 10;
    localparam int PHASE_W       = 3;
    localparam int COUNT_FIELD_W = 6;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BCAST  = 1'b1;

    localparam logic [7:0] REG_TYPE     = 8'h00;
    localparam logic [7:0] BCAST_MSG_ID = 8'h01;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic        command;
        logic        length_ok;
        logic [7:0]  pkt_type;
        logic [31:0] ip_address;
        logic [15:0] port_number;
        logic [31:0] client_id;
    } crb_req_t;

    typedef struct packed {
        logic                     result_kind;
        logic [1:0]               reg_status;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic [31:0]              echo_id;
        logic [31:0]              dest_ip;
        logic [15:0]              dest_port;
        logic [7:0]               msg_id;
        logic [FRAME_W-1:0]       frame_number;
        logic                     last;
    } crb_rsp_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
    } crb_entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } crb_cell_ctl_t;

endpackage

// ===== rtl/core/crb_cell.sv =====
// One table cell: holds an endpoint, takes its neighbour's entry on a shift or a new one on a load.
module crb_cell (
    input  logic                  clk,
    input  crb_pkg::crb_cell_ctl_t ctl,
    input  crb_pkg::crb_entry_t   neighbour,
    input  crb_pkg::crb_entry_t   load_data,
    output crb_pkg::crb_entry_t   entry
);
    import crb_pkg::*;

    crb_entry_t entry_reg;
    crb_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = load_data;
        end
        else if (ctl.shift)
        begin
            entry_next = neighbour;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/client_registry_frame_broadcast_unit.sv =====
// Top level of the client registry: a ring of entry cells and the sequencer that drives it.
//
// Usage. Request beats arrive on req_valid/req_ready, result beats leave on
// rsp_valid/rsp_ready. A registration request gives exactly one status beat.
// A tick advances the frame number; every eighth tick gives one broadcast
// beat per registered entry, in table order, with last set on the final one.
//
// Timing. The table is a ring of TABLE_DEPTH cells that rotates by one cell
// a cycle while a search or broadcast runs and no broadcast beat is stalled;
// every search or broadcast is one full turn of the ring. Broadcast beats
// leave at one a cycle while the receiver takes them. One request is handled
// at a time; req_ready is high only while idle.
//
// Reset clears the entry count, frame number and tick phase. Table contents
// are not cleared. When the receiver stalls, the result register holds its
// beat, and during a broadcast the ring stops turning until the beat is taken.
module client_registry_frame_broadcast_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  crb_pkg::crb_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output crb_pkg::crb_rsp_t rsp
);
    import crb_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_REPORT,
        S_BCAST
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                dup_reg, dup_next;
    logic [1:0]          status_reg, status_next;
    crb_entry_t          key_reg, key_next;
    logic [31:0]         echo_reg, echo_next;
    crb_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    crb_entry_t          cell_q [TABLE_DEPTH];
    crb_cell_ctl_t       cell_ctl [TABLE_DEPTH];
    logic                ring_shift;
    logic                ring_load;
    logic                slot_free;
    logic                idx_in_use;
    logic                idx_at_end;
    logic [PHASE_W-1:0]  phase_inc;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            assign cell_ctl[g].shift = ring_shift;
            assign cell_ctl[g].load  = ring_load && (count_reg == CW'(g));

            crb_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[g]),
                .neighbour (cell_q[(g + 1) % TABLE_DEPTH]),
                .load_data (key_reg),
                .entry     (cell_q[g])
            );
        end
    endgenerate

    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign idx_in_use = CW'(idx_reg) < count_reg;
    assign idx_at_end = idx_reg == IW'(TABLE_DEPTH - 1);
    assign phase_inc  = phase_reg + PHASE_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        frame_next     = frame_reg;
        phase_next     = phase_reg;
        dup_next       = dup_reg;
        status_next    = status_reg;
        key_next       = key_reg;
        echo_next      = echo_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ring_shift     = 1'b0;
        ring_load      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next.ip   = req.ip_address;
                    key_next.port = req.port_number;
                    echo_next     = req.client_id;
                    if (req.command == CMD_REGISTER)
                    begin
                        if (req.length_ok && (req.pkt_type == REG_TYPE))
                        begin
                            idx_next   = '0;
                            dup_next   = 1'b0;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_REPORT;
                        end
                    end
                    else
                    begin
                        frame_next = frame_reg + FRAME_W'(1);
                        phase_next = phase_inc;
                        if ((phase_inc == '0) && (count_reg != '0))
                        begin
                            idx_next   = '0;
                            state_next = S_BCAST;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                ring_shift = 1'b1;
                if (idx_in_use && (cell_q[0] == key_reg))
                begin
                    dup_next = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_at_end)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (dup_reg)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ADDED;
                    ring_load   = 1'b1;
                    count_next  = count_reg + CW'(1);
                end
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    rsp_next              = '0;
                    rsp_next.result_kind  = KIND_STATUS;
                    rsp_next.reg_status   = status_reg;
                    rsp_next.entry_count  = COUNT_FIELD_W'(count_reg);
                    rsp_next.echo_id      = echo_reg;
                    rsp_next.last         = 1'b1;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_BCAST:
            begin
                if (!idx_in_use || slot_free)
                begin
                    ring_shift = 1'b1;
                    idx_next   = idx_reg + IW'(1);
                    if (idx_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    if (idx_in_use)
                    begin
                        rsp_next.result_kind  = KIND_BCAST;
                        rsp_next.reg_status   = ST_ADDED;
                        rsp_next.entry_count  = COUNT_FIELD_W'(count_reg);
                        rsp_next.echo_id      = '0;
                        rsp_next.dest_ip      = cell_q[0].ip;
                        rsp_next.dest_port    = cell_q[0].port;
                        rsp_next.msg_id       = BCAST_MSG_ID;
                        rsp_next.frame_number = frame_reg;
                        rsp_next.last         = (CW'(idx_reg) + CW'(1)) == count_reg;
                        rsp_valid_next        = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            frame_reg     <= '0;
            phase_reg     <= '0;
            dup_reg       <= 1'b0;
            status_reg    <= ST_IGNORED;
            key_reg       <= '0;
            echo_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            frame_reg     <= frame_next;
            phase_reg     <= phase_next;
            dup_reg       <= dup_next;
            status_reg    <= status_next;
            key_reg       <= key_next;
            echo_reg      <= echo_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/crb_check.sv =====
// Port-level checks of the client registry unit and their binding to the top level.
module crb_check (
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input crb_pkg::crb_rsp_t rsp
);
    import crb_pkg::*;

    // A stalled result beat keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // A status beat is always the only beat of its request, with no destination or frame number.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == KIND_STATUS) |->
            rsp.last && (rsp.dest_ip == '0) && (rsp.frame_number == '0))
        else $error("malformed status beat");

    // A broadcast beat carries the fixed message identifier, no echoed client id and a nonzero entry count.
    a_bcast_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == KIND_BCAST) |->
            (rsp.msg_id == BCAST_MSG_ID) && (rsp.echo_id == '0)
            && (rsp.entry_count != '0))
        else $error("malformed broadcast beat");

    // No request is taken while a broadcast beat other than the last is waiting.
    a_bcast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == KIND_BCAST) && !rsp.last |-> !req_ready)
        else $error("request taken during a broadcast");

endmodule

bind client_registry_frame_broadcast_unit crb_check u_crb_check (.*);
